@@ design/sorted_list_engine_defines.svh @@
// Assertion macros used by the sorted list engine datapath.
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTH
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SLE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ design/sle_pkg.sv @@
// Shared types, codes and constants of the sorted list engine.
package sle_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int FUNC_W      = 2;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        FUNC_INSERT    = 2'd0,
        FUNC_POP_FIRST = 2'd1,
        FUNC_POP_LAST  = 2'd2,
        FUNC_REMOVE_AT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD_COUNT,
        PTR_LOAD_ZERO,
        PTR_LOAD_IDX,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RADDR_PTR,
        RADDR_PTR_M1,
        RADDR_PTR_P1
    } raddr_sel_t;

    typedef enum logic {
        WSRC_RDATA,
        WSRC_VALUE
    } wsrc_t;

    typedef struct packed {
        logic       load;
        logic       set_status;
        status_t    status;
        ptr_op_t    ptr_op;
        cnt_op_t    cnt_op;
        logic       rd_en;
        raddr_sel_t rd_sel;
        logic       wr_en;
        wsrc_t      wr_src;
        logic       cap_removed;
        logic       out_load;
    } sle_cmd_t;

    typedef struct packed {
        logic op_insert;
        logic full;
        logic empty;
        logic bad_pos;
        logic less;
        logic ptr_is_one;
        logic more;
        logic out_free;
    } sle_flags_t;

endpackage

@@ design/sle_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/sle_ctrl.sv @@
// Controller state machine of the sorted list engine.
module sle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sle_pkg::sle_flags_t  flags,
    output sle_pkg::sle_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WRV,
        S_RM_RD,
        S_RM_CAP,
        S_RM_SRD,
        S_RM_MOV,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (flags.op_insert)
                begin
                    if (flags.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = sle_pkg::ST_FULL;
                        state_next     = S_FINISH;
                    end
                    else if (flags.empty)
                    begin
                        cmd.ptr_op = sle_pkg::PTR_LOAD_ZERO;
                        state_next = S_INS_WRV;
                    end
                    else
                    begin
                        cmd.ptr_op = sle_pkg::PTR_LOAD_COUNT;
                        state_next = S_INS_RD;
                    end
                end
                else if (flags.empty)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sle_pkg::ST_EMPTY;
                    state_next     = S_FINISH;
                end
                else if (flags.bad_pos)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = sle_pkg::ST_BADPOS;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.ptr_op = sle_pkg::PTR_LOAD_IDX;
                    state_next = S_RM_RD;
                end
            end
            S_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sle_pkg::RADDR_PTR_M1;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (flags.less)
                begin
                    // shift the larger entry up one slot and keep walking down
                    cmd.wr_src = sle_pkg::WSRC_RDATA;
                    cmd.ptr_op = sle_pkg::PTR_DEC;
                    state_next = flags.ptr_is_one ? S_INS_WRV : S_INS_RD;
                end
                else
                begin
                    cmd.wr_src = sle_pkg::WSRC_VALUE;
                    cmd.cnt_op = sle_pkg::CNT_INC;
                    state_next = S_FINISH;
                end
            end
            S_INS_WRV:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = sle_pkg::WSRC_VALUE;
                cmd.cnt_op = sle_pkg::CNT_INC;
                state_next = S_FINISH;
            end
            S_RM_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sle_pkg::RADDR_PTR;
                state_next = S_RM_CAP;
            end
            S_RM_CAP:
            begin
                cmd.cap_removed = 1'b1;
                if (flags.more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sle_pkg::RADDR_PTR_P1;
                    state_next = S_RM_MOV;
                end
                else
                begin
                    cmd.cnt_op = sle_pkg::CNT_DEC;
                    state_next = S_FINISH;
                end
            end
            S_RM_SRD:
            begin
                if (flags.more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = sle_pkg::RADDR_PTR_P1;
                    state_next = S_RM_MOV;
                end
                else
                begin
                    cmd.cnt_op = sle_pkg::CNT_DEC;
                    state_next = S_FINISH;
                end
            end
            S_RM_MOV:
            begin
                // close the gap: move the next entry down
                cmd.wr_en  = 1'b1;
                cmd.wr_src = sle_pkg::WSRC_RDATA;
                cmd.ptr_op = sle_pkg::PTR_INC;
                state_next = S_RM_SRD;
            end
            S_FINISH:
            begin
                if (flags.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/sle_datapath.sv @@
// Datapath of the sorted list engine: operand, pointer, count and output registers.
`include "sorted_list_engine_defines.svh"

module sle_datapath #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sle_pkg::sle_cmd_t                   cmd,
    output sle_pkg::sle_flags_t                 flags,
    input  sle_pkg::func_t                      in_func,
    input  logic signed [sle_pkg::VALUE_W-1:0]  in_value,
    input  logic [sle_pkg::POS_W-1:0]           in_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sle_pkg::VALUE_W-1:0]  out_removed_value,
    output logic [sle_pkg::COUNT_W-1:0]         out_count_after,
    output sle_pkg::status_t                    out_status
);

    localparam int AW          = $clog2(DEPTH);
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int POSW        = sle_pkg::POS_W;
    localparam int VW          = sle_pkg::VALUE_W;
    localparam int COUNT_OUT_W = sle_pkg::COUNT_W;
    localparam int CMPW        = (CW > POSW) ? CW : POSW;

    sle_pkg::func_t          func_reg;
    logic signed [VW-1:0]    value_reg;
    logic [POSW-1:0]         pos_reg;
    logic [AW-1:0]           ptr_reg;
    logic [AW-1:0]           ptr_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic signed [VW-1:0]    removed_reg;
    sle_pkg::status_t        status_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [VW-1:0]    out_removed_reg;
    logic [COUNT_OUT_W-1:0]  out_count_reg;
    sle_pkg::status_t        out_status_reg;

    logic [CMPW-1:0]         idx_ext;
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic signed [VW-1:0]    ram_wr_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic signed [VW-1:0]    ram_rd_data;

    // position the removal works on
    always_comb
    begin
        case (func_reg)
            sle_pkg::FUNC_POP_FIRST: idx_ext = '0;
            sle_pkg::FUNC_POP_LAST:  idx_ext = CMPW'(count_reg - CW'(1));
            sle_pkg::FUNC_REMOVE_AT: idx_ext = CMPW'(pos_reg);
            default:                 idx_ext = '0;
        endcase
    end

    always_comb
    begin
        flags.op_insert  = (func_reg == sle_pkg::FUNC_INSERT);
        flags.full       = (count_reg == CW'(DEPTH));
        flags.empty      = (count_reg == '0);
        flags.bad_pos    = (idx_ext >= CMPW'(count_reg));
        flags.less       = (value_reg < ram_rd_data);
        flags.ptr_is_one = (ptr_reg == AW'(1));
        flags.more       = ((CW'(ptr_reg) + CW'(1)) < count_reg);
        flags.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        case (cmd.ptr_op)
            sle_pkg::PTR_LOAD_COUNT: ptr_next = AW'(count_reg);
            sle_pkg::PTR_LOAD_ZERO:  ptr_next = '0;
            sle_pkg::PTR_LOAD_IDX:   ptr_next = AW'(idx_ext);
            sle_pkg::PTR_DEC:        ptr_next = ptr_reg - AW'(1);
            sle_pkg::PTR_INC:        ptr_next = ptr_reg + AW'(1);
            default:                 ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            sle_pkg::CNT_INC: count_next = count_reg + CW'(1);
            sle_pkg::CNT_DEC: count_next = count_reg - CW'(1);
            default:          count_next = count_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_sel)
            sle_pkg::RADDR_PTR_M1: ram_rd_addr = ptr_reg - AW'(1);
            sle_pkg::RADDR_PTR_P1: ram_rd_addr = ptr_reg + AW'(1);
            default:               ram_rd_addr = ptr_reg;
        endcase
    end

    assign ram_rd_en   = cmd.rd_en;
    assign ram_wr_en   = cmd.wr_en;
    assign ram_wr_addr = ptr_reg;
    assign ram_wr_data = (cmd.wr_src == sle_pkg::WSRC_VALUE) ? value_reg : ram_rd_data;

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            func_reg    <= in_func;
            value_reg   <= in_value;
            pos_reg     <= in_position;
            removed_reg <= '0;
            status_reg  <= sle_pkg::ST_OK;
        end
        else
        begin
            if (cmd.cap_removed)
            begin
                removed_reg <= ram_rd_data;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
        end
        if (cmd.out_load)
        begin
            out_removed_reg <= removed_reg;
            out_count_reg   <= COUNT_OUT_W'(count_reg);
            out_status_reg  <= status_reg;
        end
    end

    sle_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_valid         = out_valid_reg;
    assign out_removed_value = out_removed_reg;
    assign out_count_after   = out_count_reg;
    assign out_status        = out_status_reg;

    `SLE_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "entry count above depth")
    `SLE_ASSERT(a_write_in_range, clk, rst_n, ram_wr_en |-> (CW'(ram_wr_addr) <= count_reg), "write beyond held entries")
    `SLE_ASSERT(a_full_status, clk, rst_n, (cmd.out_load && status_reg == sle_pkg::ST_FULL) |-> count_reg == CW'(DEPTH), "full status with room left")
    `SLE_ASSERT(a_refused_zero, clk, rst_n, (cmd.out_load && status_reg != sle_pkg::ST_OK) |-> removed_reg == '0, "refused operation returns a value")
    `SLE_ASSERT_NEVER(a_ptr_count_move, clk, rst_n, cmd.wr_en && cmd.cnt_op == sle_pkg::CNT_DEC, "entry written while count drops")

endmodule

@@ design/sorted_list_engine.sv @@
// Sorted list engine: bounded ascending table of signed values used as a priority queue.
// An insert moves each larger entry up one slot before writing the value; a removal moves
// each later entry down one slot; a refused item goes straight to its result.
// One item at a time: the next one is accepted in the cycle after its result is loaded, and
// a waiting result holds the engine.
// Reset clears the entry count and output valid; table contents stay undefined.
module sorted_list_engine #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sle_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // value[31:0], position[35:32]
    input  logic [sle_pkg::FUNC_W-1:0]         s_axis_tuser,  // func[1:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // removed_value[31:0], count_after[36:32]
    output logic [sle_pkg::STATUS_W-1:0]       m_axis_tuser   // status[1:0]
);

    localparam int VW   = sle_pkg::VALUE_W;
    localparam int POSW = sle_pkg::POS_W;
    localparam int COW  = sle_pkg::COUNT_W;
    localparam int OTW  = sle_pkg::OUT_TDATA_W;

    sle_pkg::sle_cmd_t    cmd;
    sle_pkg::sle_flags_t  flags;
    logic signed [VW-1:0] out_removed_value;
    logic [COW-1:0]       out_count_after;
    sle_pkg::status_t     out_status;

    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    sle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .flags             (flags),
        .in_func           (sle_pkg::func_t'(s_axis_tuser)),
        .in_value          (s_axis_tdata[VW-1:0]),
        .in_position       (s_axis_tdata[VW+POSW-1:VW]),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_removed_value (out_removed_value),
        .out_count_after   (out_count_after),
        .out_status        (out_status)
    );

    assign m_axis_tdata = {{(OTW-VW-COW){1'b0}}, out_count_after, out_removed_value};
    assign m_axis_tuser = out_status;

endmodule
